### design/iiea_pkg.sv
// ----------------------------------------------------------------------------
// iiea_pkg
// shared types and codes of the indexed insert/erase array
// ----------------------------------------------------------------------------
package iiea_pkg;

  localparam logic [2:0] REQ_PUSH   = 3'd0;
  localparam logic [2:0] REQ_POP    = 3'd1;
  localparam logic [2:0] REQ_INSERT = 3'd2;
  localparam logic [2:0] REQ_ERASE  = 3'd3;
  localparam logic [2:0] REQ_DUMP   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count_after;
    logic signed [31:0] data_out;
    logic               data_valid;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic apply;
    logic dump_step;
  } cmd_t;

  typedef struct packed {
    logic dump_more;
    logic dump_end;
  } sts_t;

endpackage

### design/iiea_ctrl.sv
// ----------------------------------------------------------------------------
// iiea_ctrl
// handshake and dump sequencing for the indexed insert/erase array
// ----------------------------------------------------------------------------
module iiea_ctrl import iiea_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free     = !out_valid_r || !out_stall;
  assign in_stall      = !((state_r == S_IDLE) && slot_free);
  assign cmd.apply     = in_valid && !in_stall;
  assign cmd.dump_step = (state_r == S_DUMP) && slot_free;
  assign out_valid     = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.apply && sts.dump_more) state_nxt = S_DUMP;
      end
      S_DUMP: begin
        if (cmd.dump_step && sts.dump_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.apply || cmd.dump_step) out_valid_nxt = 1'b1;
    else if (out_stall)             out_valid_nxt = out_valid_r;
    else                            out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/iiea_dp.sv
// ----------------------------------------------------------------------------
// iiea_dp
// shift cells, count and result register of the indexed insert/erase array
// ----------------------------------------------------------------------------
module iiea_dp import iiea_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_word_t out_word
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 5) ? CW : 5;

  logic signed [31:0] ent_r   [DEPTH];
  logic signed [31:0] ent_nxt [DEPTH];
  logic signed [31:0] up_src  [DEPTH];
  logic signed [31:0] dn_src  [DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt, cnt_new;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] pos_x, cnt_x, ins_pos;
  logic [1:0]    st;
  logic          full, empty, do_ins, do_erase, dump_go, rotate;
  out_word_t     out_r, out_nxt;

  assign pos_x   = PW'(in_word.position);
  assign cnt_x   = PW'(cnt_r);
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dump_go = (in_word.req_type == REQ_DUMP) && !empty;
  assign rotate  = cmd.dump_step || (cmd.apply && dump_go);

  // request decode
  always_comb begin
    st       = ST_OK;
    do_ins   = 1'b0;
    do_erase = 1'b0;
    ins_pos  = cnt_x;
    cnt_new  = cnt_r;
    unique case (in_word.req_type)
      REQ_PUSH: begin
        if (full) st = ST_FULL;
        else begin
          do_ins  = 1'b1;
          cnt_new = cnt_r + 1'b1;
        end
      end
      REQ_POP: begin
        if (empty) st = ST_EMPTY;
        else cnt_new = cnt_r - 1'b1;
      end
      REQ_INSERT: begin
        ins_pos = pos_x;
        if (pos_x > cnt_x) st = ST_BADPOS;
        else if (full) st = ST_FULL;
        else begin
          do_ins  = 1'b1;
          cnt_new = cnt_r + 1'b1;
        end
      end
      REQ_ERASE: begin
        if (pos_x >= cnt_x) st = ST_BADPOS;
        else begin
          do_erase = 1'b1;
          cnt_new  = cnt_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // shift cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i < DEPTH - 1) begin : g_up
      assign up_src[i] = ent_r[i+1];
    end else begin : g_wrap
      assign up_src[i] = ent_r[0];
    end
    if (i > 0) begin : g_dn
      assign dn_src[i] = ent_r[i-1];
    end else begin : g_head
      assign dn_src[i] = ent_r[0];
    end

    always_comb begin
      ent_nxt[i] = ent_r[i];
      if (rotate) begin
        if (PW'(i) < cnt_x) begin
          if (PW'(i) == cnt_x - 1'b1) ent_nxt[i] = ent_r[0];
          else                        ent_nxt[i] = up_src[i];
        end
      end else if (cmd.apply && do_ins) begin
        if (PW'(i) == ins_pos)                          ent_nxt[i] = in_word.value;
        else if (PW'(i) > ins_pos && PW'(i) <= cnt_x)   ent_nxt[i] = dn_src[i];
      end else if (cmd.apply && do_erase) begin
        if (PW'(i) >= pos_x && PW'(i) + 1'b1 < cnt_x)   ent_nxt[i] = up_src[i];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    if (cmd.apply) begin
      cnt_nxt = cnt_new;
      if (dump_go) rem_nxt = cnt_r - 1'b1;
    end else if (cmd.dump_step) begin
      rem_nxt = rem_r - 1'b1;
    end
  end

  assign sts.dump_more = dump_go && (cnt_r != CW'(1));
  assign sts.dump_end  = (rem_r == CW'(1));

  // result word
  always_comb begin
    out_nxt = out_r;
    if (cmd.dump_step) begin
      out_nxt = '{status: ST_OK, count_after: 5'(cnt_r), data_out: ent_r[0],
                  data_valid: 1'b1, last: (rem_r == CW'(1))};
    end else if (cmd.apply) begin
      if (dump_go) begin
        out_nxt = '{status: ST_OK, count_after: 5'(cnt_r), data_out: ent_r[0],
                    data_valid: 1'b1, last: (cnt_r == CW'(1))};
      end else if (in_word.req_type == REQ_DUMP) begin
        out_nxt = '{status: ST_OK, count_after: 5'(cnt_r), data_out: '0,
                    data_valid: 1'b0, last: 1'b1};
      end else begin
        out_nxt = '{status: st, count_after: 5'(cnt_new), data_out: '0,
                    data_valid: 1'b0, last: 1'b1};
      end
    end
  end

  assign out_word = out_r;

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rem_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

### design/indexed_insert_erase_array.sv
// ----------------------------------------------------------------------------
// indexed_insert_erase_array
// ordered list of signed 32-bit values with push, pop, insert, erase, dump
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall / in_word (req_type, position, value)
// result channel: out_valid / out_stall / out_word (status, count_after,
//   data_out, data_valid, last)
// a word is taken at a rising edge with valid high and stall low
// the result appears in the output register in the cycle after the request
// push, pop, insert and erase give one result each; all entries move together
//   through the shift cells, so one request per cycle is taken unless stalled
// dump gives max(1, count) results, one per cycle unless stalled, by rotating
//   the held entries through cell 0; no request is taken until the last one is out
// the output register frees in the cycle it is taken, so a new request is
//   accepted while the previous result is being read
// out_stall holds the result word; the block then stalls its input
// reset (rst_n low, synchronous) empties the list and drops any result
// ----------------------------------------------------------------------------
module indexed_insert_erase_array import iiea_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  cmd_t cmd;
  sts_t sts;
  logic in_accept;

  assign in_accept = in_valid && !in_stall;

  iiea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iiea_dp #(.DEPTH(DEPTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .cmd     (cmd),
    .sts     (sts),
    .out_word(out_word)
  );

  a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> !cmd.dump_step)
    else $error("request taken during dump");

  a_load_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply || cmd.dump_step) |=> out_valid)
    else $error("loaded result not presented");

  a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.data_valid) |-> (out_word.data_out == '0))
    else $error("data_out nonzero without data_valid");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_word.req_type != REQ_DUMP) |=> (out_valid && out_word.last))
    else $error("non-dump result without last");

endmodule
